@@ rtl/smfpa_pkg.sv @@
// Shared widths, opcodes and compare codes of the sign-magnitude fixed-point ALU.
package smfpa_pkg;

	localparam int unsigned WHOLE_W = 64;
	localparam int unsigned FRAC_W  = 64;
	localparam int unsigned OP_W    = 3;
	localparam int unsigned CMP_W   = 2;

	typedef enum logic [OP_W-1:0] {
		OP_ADD     = 3'd0,
		OP_SUB     = 3'd1,
		OP_NEGATE  = 3'd2,
		OP_HALVE   = 3'd3,
		OP_DOUBLE  = 3'd4,
		OP_COMPARE = 3'd5
	} op_t;

	localparam logic [CMP_W-1:0] CMP_LESS    = 2'b11;
	localparam logic [CMP_W-1:0] CMP_EQUAL   = 2'b00;
	localparam logic [CMP_W-1:0] CMP_GREATER = 2'b01;

endpackage

@@ rtl/sign_magnitude_fixed_point_alu.sv @@
// Top level of the pipelined sign-magnitude fixed-point ALU.
//
//  channel | handshake            | payload
//  --------+----------------------+------------------------------------------------
//  in      | in_valid / in_ready  | op, a_whole, a_frac, a_neg, b_whole, b_frac, b_neg
//  out     | out_valid/ out_ready | res_whole, res_frac, res_neg, overflow, underflow,
//          |                      | cmp_result
//
// A transaction accepted into the first stage moves through the second stage into the result
// register; one transaction enters per cycle unless an output stall has filled the
// three-stage register chain (magnitude compare, fraction add, whole-part add).
// Reset clears the stage valid bits only; data registers are not reset.
// A stall at the output holds the result stage and every full stage directly behind
// it; a stage with a bubble ahead of it still advances, so in_ready stays high while
// any bubble is left in the chain.
module sign_magnitude_fixed_point_alu (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [smfpa_pkg::OP_W-1:0]          op,
	input  logic [smfpa_pkg::WHOLE_W-1:0]       a_whole,
	input  logic [smfpa_pkg::FRAC_W-1:0]        a_frac,
	input  logic                                a_neg,
	input  logic [smfpa_pkg::WHOLE_W-1:0]       b_whole,
	input  logic [smfpa_pkg::FRAC_W-1:0]        b_frac,
	input  logic                                b_neg,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic [smfpa_pkg::WHOLE_W-1:0]       res_whole,
	output logic [smfpa_pkg::FRAC_W-1:0]        res_frac,
	output logic                                res_neg,
	output logic                                overflow,
	output logic                                underflow,
	output logic signed [smfpa_pkg::CMP_W-1:0]  cmp_result
);

	localparam int unsigned WW = smfpa_pkg::WHOLE_W;
	localparam int unsigned FW = smfpa_pkg::FRAC_W;
	localparam int unsigned CW = smfpa_pkg::CMP_W;

	// Stage handshake: a stage takes new data when it is empty or when the
	// stage after it is moving.
	logic v_s1, v_s2, v_s3;
	logic rdy1, rdy2, rdy3;

	assign rdy3     = !v_s3 || out_ready;
	assign rdy2     = !v_s2 || rdy3;
	assign rdy1     = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 1: register operands with the 64-bit magnitude compares.
	// Subtract flips B's sign here unless B is zero.
	// ---------------------------------------------------------------------
	smfpa_pkg::op_t    op_s1;
	logic [WW-1:0]     aw_s1, bw_s1;
	logic [FW-1:0]     af_s1, bf_s1;
	logic              an_s1, bn_s1;
	logic              wlt_s1, weq_s1, flt_s1, feq_s1, az_s1, bz_s1;

	logic b_zero_in;
	assign b_zero_in = (b_whole == '0) && (b_frac == '0);

	always_ff @(posedge clk) begin
		if (rdy1) begin
			op_s1  <= smfpa_pkg::op_t'(op);
			aw_s1  <= a_whole;
			af_s1  <= a_frac;
			an_s1  <= a_neg;
			bw_s1  <= b_whole;
			bf_s1  <= b_frac;
			bn_s1  <= (smfpa_pkg::op_t'(op) == smfpa_pkg::OP_SUB && !b_zero_in)
				? !b_neg : b_neg;
			wlt_s1 <= a_whole < b_whole;
			weq_s1 <= a_whole == b_whole;
			flt_s1 <= a_frac < b_frac;
			feq_s1 <= a_frac == b_frac;
			az_s1  <= (a_whole == '0) && (a_frac == '0);
			bz_s1  <= b_zero_in;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 2: pick larger/smaller, add or subtract the fractions, and work
	// out the operations that need no whole-part add (negate, shifts, compare).
	// ---------------------------------------------------------------------
	logic          a_lt_b, b_lt_a, same, swap, is_arith;
	logic [FW-1:0] gf, lf;
	logic [FW:0]   fsum;
	logic [CW-1:0] cmp_d;

	logic [WW-1:0] o_whole_d;
	logic [FW-1:0] o_frac_d;
	logic          o_neg_d, o_ov_d, o_uf_d;

	assign a_lt_b   = wlt_s1 || (weq_s1 && flt_s1);
	assign b_lt_a   = (!wlt_s1 && !weq_s1) || (weq_s1 && !flt_s1 && !feq_s1);
	assign same     = an_s1 == bn_s1;
	assign swap     = !same && a_lt_b;
	assign gf       = swap ? bf_s1 : af_s1;
	assign lf       = swap ? af_s1 : bf_s1;
	assign is_arith = (op_s1 == smfpa_pkg::OP_ADD) || (op_s1 == smfpa_pkg::OP_SUB);
	// Add: plain sum with carry. Subtract: carry out is the inverse of borrow,
	// which is exactly the carry-in the whole part needs in both cases.
	assign fsum = {1'b0, gf} + {1'b0, (same ? lf : ~lf)} + {{FW{1'b0}}, !same};

	always_comb begin
		o_whole_d = '0;
		o_frac_d  = '0;
		o_neg_d   = 1'b0;
		o_ov_d    = 1'b0;
		o_uf_d    = 1'b0;
		cmp_d     = smfpa_pkg::CMP_EQUAL;
		case (op_s1)
			smfpa_pkg::OP_NEGATE: begin
				o_whole_d = aw_s1;
				o_frac_d  = af_s1;
				o_neg_d   = az_s1 ? an_s1 : !an_s1;
			end
			smfpa_pkg::OP_HALVE: begin
				o_uf_d    = af_s1[0];
				o_frac_d  = {aw_s1[0], af_s1[FW-1:1]};
				o_whole_d = {1'b0, aw_s1[WW-1:1]};
				o_neg_d   = an_s1;
			end
			smfpa_pkg::OP_DOUBLE: begin
				o_ov_d    = aw_s1[WW-1];
				o_whole_d = {aw_s1[WW-2:0], af_s1[FW-1]};
				o_frac_d  = {af_s1[FW-2:0], 1'b0};
				o_neg_d   = an_s1;
			end
			smfpa_pkg::OP_COMPARE: begin
				if (same) begin
					if (b_lt_a)
						cmp_d = an_s1 ? smfpa_pkg::CMP_LESS : smfpa_pkg::CMP_GREATER;
					else if (a_lt_b)
						cmp_d = an_s1 ? smfpa_pkg::CMP_GREATER : smfpa_pkg::CMP_LESS;
				end else if (!(az_s1 && bz_s1)) begin
					cmp_d = an_s1 ? smfpa_pkg::CMP_LESS : smfpa_pkg::CMP_GREATER;
				end
			end
			default: begin
			end
		endcase
	end

	logic          arith_s2, same_s2, sign_s2, cin_s2;
	logic [WW-1:0] gw_s2, lw_s2;
	logic [FW-1:0] f_s2;
	logic [WW-1:0] o_whole_s2;
	logic [FW-1:0] o_frac_s2;
	logic          o_neg_s2, o_ov_s2, o_uf_s2;
	logic [CW-1:0] cmp_s2;

	always_ff @(posedge clk) begin
		if (rdy2) begin
			arith_s2   <= is_arith;
			same_s2    <= same;
			sign_s2    <= swap ? bn_s1 : an_s1;
			cin_s2     <= fsum[FW];
			gw_s2      <= swap ? bw_s1 : aw_s1;
			// Hold the smaller whole part already inverted when subtracting.
			lw_s2      <= same ? bw_s1 : (swap ? ~aw_s1 : ~bw_s1);
			f_s2       <= fsum[FW-1:0];
			o_whole_s2 <= o_whole_d;
			o_frac_s2  <= o_frac_d;
			o_neg_s2   <= o_neg_d;
			o_ov_s2    <= o_ov_d;
			o_uf_s2    <= o_uf_d;
			cmp_s2     <= cmp_d;
		end
	end

	// ---------------------------------------------------------------------
	// Stage 3: whole-part add with the fraction carry, then select the result.
	// ---------------------------------------------------------------------
	logic [WW:0] wsum;
	assign wsum = {1'b0, gw_s2} + {1'b0, lw_s2} + {{WW{1'b0}}, cin_s2};

	logic [WW-1:0] res_whole_s3;
	logic [FW-1:0] res_frac_s3;
	logic          res_neg_s3, ov_s3, uf_s3;
	logic [CW-1:0] cmp_s3;

	always_ff @(posedge clk) begin
		if (rdy3) begin
			if (arith_s2) begin
				res_whole_s3 <= wsum[WW-1:0];
				res_frac_s3  <= f_s2;
				res_neg_s3   <= sign_s2;
				ov_s3        <= same_s2 && wsum[WW];
				uf_s3        <= 1'b0;
				cmp_s3       <= smfpa_pkg::CMP_EQUAL;
			end else begin
				res_whole_s3 <= o_whole_s2;
				res_frac_s3  <= o_frac_s2;
				res_neg_s3   <= o_neg_s2;
				ov_s3        <= o_ov_s2;
				uf_s3        <= o_uf_s2;
				cmp_s3       <= cmp_s2;
			end
		end
	end

	assign out_valid  = v_s3;
	assign res_whole  = res_whole_s3;
	assign res_frac   = res_frac_s3;
	assign res_neg    = res_neg_s3;
	assign overflow   = ov_s3;
	assign underflow  = uf_s3;
	assign cmp_result = cmp_s3;

endmodule

@@ rtl/smfpa_checker.sv @@
// Port-level checks of the sign-magnitude fixed-point ALU, bound to the top level.
module smfpa_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                in_valid,
	input logic                                in_ready,
	input logic [smfpa_pkg::OP_W-1:0]          op,
	input logic [smfpa_pkg::WHOLE_W-1:0]       a_whole,
	input logic [smfpa_pkg::FRAC_W-1:0]        a_frac,
	input logic                                a_neg,
	input logic [smfpa_pkg::WHOLE_W-1:0]       b_whole,
	input logic [smfpa_pkg::FRAC_W-1:0]        b_frac,
	input logic                                b_neg,
	input logic                                out_valid,
	input logic                                out_ready,
	input logic [smfpa_pkg::WHOLE_W-1:0]       res_whole,
	input logic [smfpa_pkg::FRAC_W-1:0]        res_frac,
	input logic                                res_neg,
	input logic                                overflow,
	input logic                                underflow,
	input logic signed [smfpa_pkg::CMP_W-1:0]  cmp_result
);

	// Stalled result holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(res_whole) && $stable(res_frac)
			&& $stable(cmp_result))
		else $error("stalled result changed");

	// A moving output leaves room at the input.
	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("input blocked while output drains");

	// A compare result carries no magnitude, sign or flags.
	a_cmp_only: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cmp_result != smfpa_pkg::CMP_EQUAL |->
			res_whole == '0 && res_frac == '0 && !res_neg && !overflow && !underflow)
		else $error("compare result mixed with arithmetic fields");

	// No operation sets both flags, and the compare code is always a defined one.
	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(overflow && underflow)
			&& (cmp_result == smfpa_pkg::CMP_LESS || cmp_result == smfpa_pkg::CMP_EQUAL
				|| cmp_result == smfpa_pkg::CMP_GREATER))
		else $error("illegal flag combination");

endmodule

bind sign_magnitude_fixed_point_alu smfpa_checker u_smfpa_checker (.*);

@@ verif/sign_magnitude_fixed_point_alu_tb.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the sign-magnitude fixed-point ALU, directed and random.
module sign_magnitude_fixed_point_alu_tb;

	// Opcodes outside the defined set; the block answers them with an all-zero result.
	localparam logic [smfpa_pkg::OP_W-1:0] OP_SPARE_6 = 3'd6;
	localparam logic [smfpa_pkg::OP_W-1:0] OP_SPARE_7 = 3'd7;

	localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] TOP_ONLY = 64'h8000_0000_0000_0000;

	localparam int MAX_WAIT    = 11;
	localparam int DRAIN_TAIL  = 10;
	localparam int CYCLE_LIMIT = 200000;

	// One operation as presented on the input channel.
	typedef struct packed {
		logic [smfpa_pkg::OP_W-1:0]    opcode;
		logic [smfpa_pkg::WHOLE_W-1:0] a_whole;
		logic [smfpa_pkg::FRAC_W-1:0]  a_frac;
		logic                          a_neg;
		logic [smfpa_pkg::WHOLE_W-1:0] b_whole;
		logic [smfpa_pkg::FRAC_W-1:0]  b_frac;
		logic                          b_neg;
	} alu_item_t;

	// One result as presented on the output channel.
	typedef struct packed {
		logic [smfpa_pkg::WHOLE_W-1:0] res_whole;
		logic [smfpa_pkg::FRAC_W-1:0]  res_frac;
		logic                          res_neg;
		logic                          overflow;
		logic                          underflow;
		logic [smfpa_pkg::CMP_W-1:0]   cmp;
	} alu_result_t;

	logic                                 clk        = 1'b0;
	logic                                 arst_n     = 1'b0;
	logic                                 in_valid   = 1'b0;
	logic                                 in_ready;
	logic [smfpa_pkg::OP_W-1:0]           op         = '0;
	logic [smfpa_pkg::WHOLE_W-1:0]        a_whole    = '0;
	logic [smfpa_pkg::FRAC_W-1:0]         a_frac     = '0;
	logic                                 a_neg      = 1'b0;
	logic [smfpa_pkg::WHOLE_W-1:0]        b_whole    = '0;
	logic [smfpa_pkg::FRAC_W-1:0]         b_frac     = '0;
	logic                                 b_neg      = 1'b0;
	logic                                 out_valid;
	logic                                 out_ready  = 1'b0;
	logic [smfpa_pkg::WHOLE_W-1:0]        res_whole;
	logic [smfpa_pkg::FRAC_W-1:0]         res_frac;
	logic                                 res_neg;
	logic                                 overflow;
	logic                                 underflow;
	logic signed [smfpa_pkg::CMP_W-1:0]   cmp_result;

	alu_result_t pending_results[$];
	int          fail_count = 0;
	int          cycle_count = 0;
	// Clear to run both channels without any idle cycles.
	bit          idle_on = 1'b1;

	sign_magnitude_fixed_point_alu DUT (.*);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Abort a hung run.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	// Draw the idle cycles one side spends before its next transaction.
	function automatic int draw_wait();
		if (!idle_on)
			return 0;
		return $urandom_range(0, MAX_WAIT);
	endfunction

	// Add two signed magnitudes: sum on equal signs with carry out, otherwise take the
	// smaller from the larger and keep the larger one's sign (A's sign on a tie).
	function automatic alu_result_t signed_sum(logic [127:0] a_mag, logic a_sign,
			logic [127:0] b_mag, logic b_sign);
		alu_result_t r;
		logic [128:0] total;
		r = '0;
		if (a_sign == b_sign) begin
			total = {1'b0, a_mag} + {1'b0, b_mag};
			{r.res_whole, r.res_frac} = total[127:0];
			r.overflow = total[128];
			r.res_neg = a_sign;
		end else if (a_mag < b_mag) begin
			{r.res_whole, r.res_frac} = b_mag - a_mag;
			r.res_neg = b_sign;
		end else begin
			{r.res_whole, r.res_frac} = a_mag - b_mag;
			r.res_neg = a_sign;
		end
		return r;
	endfunction

	// Work out the result the block owes for one operation.
	function automatic alu_result_t fixed_point_result(alu_item_t it);
		alu_result_t r;
		logic [127:0] a_mag;
		logic [127:0] b_mag;
		logic [127:0] shifted;
		r = '0;
		a_mag = {it.a_whole, it.a_frac};
		b_mag = {it.b_whole, it.b_frac};
		case (it.opcode)
			smfpa_pkg::OP_ADD: begin
				r = signed_sum(a_mag, it.a_neg, b_mag, it.b_neg);
			end
			smfpa_pkg::OP_SUB: begin
				// A zero subtrahend keeps its sign.
				r = signed_sum(a_mag, it.a_neg, b_mag, (b_mag != 0) ? !it.b_neg : it.b_neg);
			end
			smfpa_pkg::OP_NEGATE: begin
				{r.res_whole, r.res_frac} = a_mag;
				r.res_neg = (a_mag != 0) ? !it.a_neg : it.a_neg;
			end
			smfpa_pkg::OP_HALVE: begin
				shifted = a_mag >> 1;
				{r.res_whole, r.res_frac} = shifted;
				r.res_neg = it.a_neg;
				r.underflow = it.a_frac[0];
			end
			smfpa_pkg::OP_DOUBLE: begin
				shifted = a_mag << 1;
				{r.res_whole, r.res_frac} = shifted;
				r.res_neg = it.a_neg;
				r.overflow = it.a_whole[smfpa_pkg::WHOLE_W-1];
			end
			smfpa_pkg::OP_COMPARE: begin
				if (it.a_neg == it.b_neg) begin
					if (a_mag > b_mag)
						r.cmp = it.a_neg ? smfpa_pkg::CMP_LESS : smfpa_pkg::CMP_GREATER;
					else if (a_mag < b_mag)
						r.cmp = it.a_neg ? smfpa_pkg::CMP_GREATER : smfpa_pkg::CMP_LESS;
					else
						r.cmp = smfpa_pkg::CMP_EQUAL;
				end else if (a_mag == 0 && b_mag == 0) begin
					// Zeros of either sign are equal.
					r.cmp = smfpa_pkg::CMP_EQUAL;
				end else begin
					r.cmp = it.a_neg ? smfpa_pkg::CMP_LESS : smfpa_pkg::CMP_GREATER;
				end
			end
			default: begin
				r = '0;
			end
		endcase
		return r;
	endfunction

	function automatic alu_item_t make_item(logic [smfpa_pkg::OP_W-1:0] code,
			logic [63:0] aw, logic [63:0] af, logic an,
			logic [63:0] bw, logic [63:0] bf, logic bn);
		alu_item_t it;
		it.opcode = code;
		it.a_whole = aw;
		it.a_frac = af;
		it.a_neg = an;
		it.b_whole = bw;
		it.b_frac = bf;
		it.b_neg = bn;
		return it;
	endfunction

	function automatic logic [63:0] random_word();
		return {$urandom, $urandom};
	endfunction

	// Pick a magnitude, biased toward the corners that matter for carries and borrows.
	function automatic logic [127:0] random_magnitude();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return {ALL_ONES, ALL_ONES};
			2: return {64'd0, random_word()};
			3: return {64'($urandom_range(0, 15)), random_word()};
			4: return {TOP_ONLY, TOP_ONLY} | 128'($urandom_range(0, 3));
			default: return {random_word(), random_word()};
		endcase
	endfunction

	// Mostly defined opcodes, now and then a spare one.
	function automatic logic [smfpa_pkg::OP_W-1:0] random_opcode();
		if ($urandom_range(0, 39) == 0)
			return $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7;
		return smfpa_pkg::op_t'($urandom_range(smfpa_pkg::OP_ADD,
				smfpa_pkg::OP_COMPARE));
	endfunction

	// Present one transaction after a random gap and hold it until it is taken.
	// Leaves in_valid high, so a back-to-back caller can redrive it at the same edge.
	task automatic send_transaction(input alu_item_t it);
		int gap;
		gap = draw_wait();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op       <= it.opcode;
		a_whole  <= it.a_whole;
		a_frac   <= it.a_frac;
		a_neg    <= it.a_neg;
		b_whole  <= it.b_whole;
		b_frac   <= it.b_frac;
		b_neg    <= it.b_neg;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(fixed_point_result(it));
	endtask

	// Stall the output channel at random; hold ready until a result is taken.
	initial begin
		int stall;
		wait (arst_n);
		@(posedge clk);
		forever begin
			stall = draw_wait();
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!out_valid)
				@(posedge clk);
		end
	end

	task automatic check_field(input string name, input logic [63:0] want,
			input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %h, actual %h", name, want, got);
			fail_count++;
		end
	endtask

	// Match every taken result against the oldest outstanding prediction.
	always @(posedge clk) begin : check_results
		alu_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no transaction outstanding");
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				check_field("res_whole", want.res_whole, res_whole);
				check_field("res_frac", want.res_frac, res_frac);
				check_field("res_neg", 64'(want.res_neg), 64'(res_neg));
				check_field("overflow", 64'(want.overflow), 64'(overflow));
				check_field("underflow", 64'(want.underflow), 64'(underflow));
				check_field("cmp_result", 64'(want.cmp), 64'($unsigned(cmp_result)));
			end
		end
	end

	// Add and subtract: carry out, carry from fraction, borrow, equal magnitudes, zero signs.
	task automatic test_add_subtract_edges();
		send_transaction(make_item(smfpa_pkg::OP_ADD, ALL_ONES, ALL_ONES, 1'b0,
				ALL_ONES, ALL_ONES, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_ADD, 64'd1, TOP_ONLY, 1'b0,
				64'd1, TOP_ONLY, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_ADD, 64'd0, ALL_ONES, 1'b1,
				64'd1, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_ADD, 64'd0, ALL_ONES, 1'b1,
				64'd0, 64'd1, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_ADD, 64'd0, 64'd0, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_SUB, 64'd5, 64'd0, 1'b0,
				64'd0, 64'd0, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_SUB, 64'd3, 64'h4000_0000_0000_0000, 1'b1,
				64'd3, 64'h4000_0000_0000_0000, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_SUB, ALL_ONES, ALL_ONES, 1'b0,
				ALL_ONES, ALL_ONES, 1'b1));
	endtask

	// Negate, halve and double, including negative zero and bits shifted out.
	task automatic test_unary_edges();
		send_transaction(make_item(smfpa_pkg::OP_NEGATE, 64'd7, 64'h1234, 1'b0,
				ALL_ONES, ALL_ONES, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_NEGATE, 64'd0, 64'd0, 1'b1,
				64'd9, 64'd9, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_NEGATE, 64'd0, 64'd0, 1'b0,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_NEGATE, ALL_ONES, ALL_ONES, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_HALVE, 64'd3, 64'd1, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_HALVE, ALL_ONES, ALL_ONES, 1'b0,
				ALL_ONES, ALL_ONES, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_HALVE, 64'd0, 64'd0, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_DOUBLE, TOP_ONLY, TOP_ONLY, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_DOUBLE, ALL_ONES, ALL_ONES, 1'b0,
				64'd0, 64'd0, 1'b1));
	endtask

	// Compare across signs, with zeros of both signs and ties in the whole part.
	task automatic test_compare_edges();
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, 64'd0, 64'd0, 1'b0,
				64'd0, 64'd0, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, 64'd0, 64'd0, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, 64'd1, 64'd0, 1'b1,
				64'd2, 64'd0, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, 64'd0, 64'd1, 1'b0,
				ALL_ONES, ALL_ONES, 1'b1));
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, 64'd0, 64'd1, 1'b1,
				64'd0, 64'd0, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, ALL_ONES, ALL_ONES, 1'b0,
				ALL_ONES, ALL_ONES, 1'b0));
		send_transaction(make_item(smfpa_pkg::OP_COMPARE, 64'd4, 64'd2, 1'b0,
				64'd4, 64'd3, 1'b0));
	endtask

	// Spare opcodes must give an all-zero result.
	task automatic test_spare_opcodes();
		send_transaction(make_item(OP_SPARE_6, ALL_ONES, ALL_ONES, 1'b1, ALL_ONES, ALL_ONES, 1'b1));
		send_transaction(make_item(OP_SPARE_7, TOP_ONLY, 64'd1, 1'b0, 64'd1, TOP_ONLY, 1'b1));
	endtask

	// Fully random operations and operands.
	task automatic test_random_mix(input int count);
		logic [127:0] a_mag;
		logic [127:0] b_mag;
		for (int i = 0; i < count; i++) begin
			a_mag = random_magnitude();
			b_mag = random_magnitude();
			send_transaction(make_item(random_opcode(), a_mag[127:64], a_mag[63:0],
					1'($urandom_range(0, 1)), b_mag[127:64], b_mag[63:0],
					1'($urandom_range(0, 1))));
		end
	endtask

	// Add, subtract and compare with B equal to A, just above or below it, or one bit apart, to reach ties and borrows.
	task automatic test_random_near_ties(input int count);
		logic [127:0] a_mag;
		logic [127:0] b_mag;
		logic [smfpa_pkg::OP_W-1:0] code;
		for (int i = 0; i < count; i++) begin
			a_mag = random_magnitude();
			case ($urandom_range(0, 3))
				0: b_mag = a_mag;
				1: b_mag = a_mag + 128'($urandom_range(1, 3));
				2: b_mag = a_mag - 128'($urandom_range(1, 3));
				default: b_mag = a_mag ^ (128'd1 << $urandom_range(0, 127));
			endcase
			case ($urandom_range(0, 2))
				0: code = smfpa_pkg::OP_ADD;
				1: code = smfpa_pkg::OP_SUB;
				default: code = smfpa_pkg::OP_COMPARE;
			endcase
			send_transaction(make_item(code, a_mag[127:64], a_mag[63:0],
					1'($urandom_range(0, 1)), b_mag[127:64], b_mag[63:0],
					1'($urandom_range(0, 1))));
		end
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_add_subtract_edges();
		test_unary_edges();
		test_compare_edges();
		test_spare_opcodes();

		test_random_mix(1000);
		test_random_near_ties(300);
		// Drop all idling on both sides to run the pipeline at full rate.
		idle_on = 1'b0;
		test_random_mix(250);
		test_random_near_ties(100);
		idle_on = 1'b1;
		test_random_mix(50);

		// Release the input and drain every outstanding result, then watch for strays.
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_TAIL) @(posedge clk);

		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
